// ===== rtl/core/rmts_pkg.sv =====
// Shared types and constants of the rate-monotonic task scheduler.
// Action, status and task-mode codes plus fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmts_pkg;

	// Field widths fixed by the stream format.
	localparam int TASK_ID_W = 22;
	localparam int PERIOD_W  = 20;
	localparam int SHARE_W   = 11;
	localparam int MODE_W    = 2;
	localparam int WAIT_W    = 21;
	localparam int TIME_W    = 32;
	localparam int LIMIT_W   = 10;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 2;

	// Share arithmetic.
	localparam int PERMILLE  = 1000;
	localparam int PROD_W    = 30;
	localparam int SHARE_MAX = 2047;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd694;

	// Actions carried in the input tuser.
	localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_YIELD      = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DEREGISTER = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STS_REFUSED = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] STS_UNKNOWN = 2'd3;

	// Task modes.
	localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/rmts_share_div.sv =====
// Share calculator: compute_ms * 1000 / period_ms, saturated to 11 bits.
// The product is registered at start, then a restoring divider yields one quotient bit per cycle.
// Depends on rmts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmts_share_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [rmts_pkg::PERIOD_W-1:0] compute,
	input  wire [rmts_pkg::PERIOD_W-1:0] period,
	output logic                         done,
	output logic [rmts_pkg::SHARE_W-1:0] share
);

	localparam int CntW = $clog2(rmts_pkg::PROD_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CntW-1:0]               cnt_q;
	logic [rmts_pkg::PROD_W-1:0]   dvd_q;
	logic [rmts_pkg::PERIOD_W:0]   rem_q;
	logic [rmts_pkg::PERIOD_W-1:0] dvs_q;
	logic [rmts_pkg::PERIOD_W:0]   rem_sh;
	logic                          q_bit;
	logic [rmts_pkg::PERIOD_W:0]   rem_nx;

	// One restoring step on the partial remainder.
	always_comb begin
		rem_sh = {rem_q[rmts_pkg::PERIOD_W-1:0], dvd_q[rmts_pkg::PROD_W-1]};
		q_bit  = (rem_sh >= {1'b0, dvs_q});
		rem_nx = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// The product is registered at start; the quotient then shifts into dvd_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntW'(rmts_pkg::PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= rmts_pkg::PROD_W'(compute) * rmts_pkg::PROD_W'(rmts_pkg::PERMILLE);
			dvs_q <= period;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rmts_pkg::PROD_W-2:0], q_bit};
			rem_q <= rem_nx;
		end
	end

	assign done  = done_q;
	assign share = (dvd_q[rmts_pkg::PROD_W-1:rmts_pkg::SHARE_W] != '0)
		? rmts_pkg::SHARE_W'(rmts_pkg::SHARE_MAX) : dvd_q[rmts_pkg::SHARE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/rmts_task_mem.sv =====
// Task table memory: one write port, one read port, registered read data.
// Generic width and depth; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmts_task_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire [WIDTH-1:0]  wdata,
	input  wire              re,
	input  wire [AW-1:0]     raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rate_monotonic_task_scheduler.sv =====
// Rate-monotonic task scheduler with utilisation admission.
// Sequencer over the task table memory; uses rmts_pkg, rmts_share_div and rmts_task_mem.
//
// Usage: one command transaction on the s_ channel (action in s_tuser, task id,
// period and compute time in s_tdata) yields exactly one result transaction on
// the m_ channel (status, running flag, running id and switch flag).
// share_limit is written through share_limit_we/share_limit_wdata; the user must
// write it only while idle, which the block itself does not enforce. Each command
// walks the task table, which sits in a synchronous memory with a registered
// read, so every entry visited takes a read state and an evaluate state. A
// command walks the table for its action and then walks it again to pick the
// running task; a register also waits for the share divider, overlapped with
// its walk, and for its insertion shift. s_tready is high only while the
// sequencer is idle. The result sits in an output register; a stalled receiver
// holds it there while the next command is already accepted and worked on, and
// only the loading of the following result waits. Reset empties the table,
// zeroes time, clears the running task and sets share_limit to 694; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module rate_monotonic_task_scheduler #(
	parameter int MAX_TASKS = 16,
	parameter int ID_BITS   = 22
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          share_limit_we,
	input  wire [rmts_pkg::LIMIT_W-1:0]  share_limit_wdata,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [63:0]                   s_tdata,   // task_id, period_ms, compute_ms, zero pad
	input  wire [rmts_pkg::ACTION_W-1:0] s_tuser,   // action
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [31:0]                  m_tdata    // status, running_valid, running_id, switched, pad
);

	localparam int SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CntW  = $clog2(MAX_TASKS + 1);
	localparam int IdW   = (ID_BITS < rmts_pkg::TASK_ID_W) ? ID_BITS : rmts_pkg::TASK_ID_W;
	localparam int RecW  = IdW + rmts_pkg::PERIOD_W + rmts_pkg::SHARE_W + rmts_pkg::MODE_W
		+ rmts_pkg::WAIT_W + rmts_pkg::TIME_W;
	localparam int TotW  = $clog2((MAX_TASKS + 1) * rmts_pkg::SHARE_MAX + 1);

	// Sequencer states.
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_REG_RD = 5'd1;
	localparam logic [4:0] ST_REG_DO = 5'd2;
	localparam logic [4:0] ST_REG_CK = 5'd3;
	localparam logic [4:0] ST_SHU_RD = 5'd4;
	localparam logic [4:0] ST_SHU_DO = 5'd5;
	localparam logic [4:0] ST_INS    = 5'd6;
	localparam logic [4:0] ST_FND_RD = 5'd7;
	localparam logic [4:0] ST_FND_DO = 5'd8;
	localparam logic [4:0] ST_YLD_WR = 5'd9;
	localparam logic [4:0] ST_DSH_RD = 5'd10;
	localparam logic [4:0] ST_DSH_DO = 5'd11;
	localparam logic [4:0] ST_TK_RD  = 5'd12;
	localparam logic [4:0] ST_TK_DO  = 5'd13;
	localparam logic [4:0] ST_PK_RD  = 5'd14;
	localparam logic [4:0] ST_PK_DO  = 5'd15;
	localparam logic [4:0] ST_PK_ORD = 5'd16;
	localparam logic [4:0] ST_PK_OWR = 5'd17;
	localparam logic [4:0] ST_PK_NEW = 5'd18;
	localparam logic [4:0] ST_FIN    = 5'd19;

	logic [4:0]                    state_q;
	logic [rmts_pkg::ACTION_W-1:0] act_q;
	logic [IdW-1:0]                id_q;
	logic [rmts_pkg::PERIOD_W-1:0] period_q;
	logic [CntW-1:0]               idx_q;
	logic [CntW-1:0]               pos_q;
	logic                          pos_found_q;
	logic [TotW-1:0]               total_q;
	logic [rmts_pkg::STATUS_W-1:0] status_q;
	logic [CntW-1:0]               count_q;
	logic                          cur_valid_q;
	logic [SlotW-1:0]              cur_slot_q;
	logic [IdW-1:0]                cur_id_q;
	logic                          old_valid_q;
	logic [IdW-1:0]                old_id_q;
	logic [rmts_pkg::TIME_W-1:0]   now_q;
	logic [rmts_pkg::LIMIT_W-1:0]  limit_q;
	logic [RecW-1:0]               rec_q;
	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;

	// Memory port.
	logic             mem_we;
	logic [SlotW-1:0] mem_waddr;
	logic [RecW-1:0]  mem_wdata;
	logic             mem_re;
	logic [SlotW-1:0] mem_raddr;
	logic [RecW-1:0]  mem_rdata;

	// Divider port.
	logic                          div_start;
	logic                          div_done;
	logic [rmts_pkg::SHARE_W-1:0]  div_share;

	// Fields of the entry just read and of the held entry.
	logic [IdW-1:0]                rd_id,     rq_id;
	logic [rmts_pkg::PERIOD_W-1:0] rd_period, rq_period;
	logic [rmts_pkg::SHARE_W-1:0]  rd_share,  rq_share;
	logic [rmts_pkg::MODE_W-1:0]   rd_mode,   rq_mode;
	logic [rmts_pkg::WAIT_W-1:0]   rd_wait,   rq_wait;
	logic [rmts_pkg::TIME_W-1:0]   rd_start,  rq_start;

	assign {rd_id, rd_period, rd_share, rd_mode, rd_wait, rd_start} = mem_rdata;
	assign {rq_id, rq_period, rq_share, rq_mode, rq_wait, rq_start} = rec_q;

	logic                          accept;
	logic [CntW-1:0]               idx_m1;
	logic [CntW-1:0]               idx_p1;
	logic [TotW-1:0]               total_new;
	logic [rmts_pkg::TIME_W-1:0]   elapsed;
	logic [rmts_pkg::WAIT_W-1:0]   yld_wait;
	logic [rmts_pkg::MODE_W-1:0]   tk_mode;
	logic [rmts_pkg::WAIT_W-1:0]   tk_wait;
	logic                          out_free;
	logic [IdW-1:0]                new_id;
	logic                          switched;

	assign accept    = s_tvalid && s_tready;
	assign idx_m1    = idx_q - 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign total_new = total_q + TotW'(div_share);
	assign out_free  = !m_tvalid_q || m_tready;
	assign new_id    = cur_valid_q ? cur_id_q : '0;
	assign switched  = (old_valid_q != cur_valid_q) || (old_id_q != new_id);
	assign div_start = accept && (s_tuser == rmts_pkg::ACT_REGISTER)
		&& (s_tdata[41:22] != '0);

	// Wake-up time left after a yield; a late yield wakes on the next tick.
	always_comb begin
		elapsed = now_q - rq_start;
		if (elapsed < rmts_pkg::TIME_W'(rq_period)) begin
			yld_wait = rmts_pkg::WAIT_W'(rq_period) - rmts_pkg::WAIT_W'(elapsed);
		end else begin
			yld_wait = rmts_pkg::WAIT_W'(1);
		end
	end

	// Tick countdown of one sleeping entry.
	always_comb begin
		tk_mode = rd_mode;
		tk_wait = rd_wait;
		if (rd_mode == rmts_pkg::MODE_SLEEP && rd_wait != '0) begin
			tk_wait = rd_wait - 1'b1;
			if (rd_wait == rmts_pkg::WAIT_W'(1)) begin
				tk_mode = rmts_pkg::MODE_READY;
			end
		end
	end

	// Memory accesses issued by the current sequencer state.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q[SlotW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q[SlotW-1:0];
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_REG_RD, ST_FND_RD, ST_TK_RD, ST_PK_RD: begin
				mem_re = (idx_q < count_q);
			end
			ST_SHU_RD: begin
				mem_re    = (idx_q > pos_q);
				mem_raddr = idx_m1[SlotW-1:0];
			end
			ST_SHU_DO, ST_DSH_DO: begin
				mem_we = 1'b1;
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[SlotW-1:0];
				mem_wdata = {id_q, period_q, div_share, rmts_pkg::MODE_SLEEP,
					rmts_pkg::WAIT_W'(0), now_q};
			end
			ST_YLD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {rq_id, rq_period, rq_share, rmts_pkg::MODE_SLEEP,
					yld_wait, rq_start};
			end
			ST_DSH_RD: begin
				mem_re    = (idx_p1 < count_q);
				mem_raddr = idx_p1[SlotW-1:0];
			end
			ST_TK_DO: begin
				mem_we    = 1'b1;
				mem_wdata = {rd_id, rd_period, rd_share, tk_mode, tk_wait, rd_start};
			end
			ST_PK_ORD: begin
				mem_re    = 1'b1;
				mem_raddr = cur_slot_q;
			end
			ST_PK_OWR: begin
				mem_we    = 1'b1;
				mem_waddr = cur_slot_q;
				mem_wdata = {rd_id, rd_period, rd_share, rmts_pkg::MODE_READY,
					rd_wait, rd_start};
			end
			ST_PK_NEW: begin
				mem_we    = 1'b1;
				mem_wdata = {rq_id, rq_period, rq_share, rmts_pkg::MODE_RUN,
					rq_wait, now_q};
			end
			default: begin
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= rmts_pkg::LIMIT_RESET;
		end else if (share_limit_we) begin
			limit_q <= share_limit_wdata;
		end
	end

	// Sequencer and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			now_q       <= '0;
			m_tvalid_q  <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			pos_found_q <= 1'b0;
			total_q     <= '0;
			status_q    <= rmts_pkg::STS_OK;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q       <= '0;
						total_q     <= '0;
						pos_found_q <= 1'b0;
						status_q    <= rmts_pkg::STS_OK;
						unique case (s_tuser)
							rmts_pkg::ACT_REGISTER: begin
								if (s_tdata[41:22] == '0) begin
									status_q <= rmts_pkg::STS_REFUSED;
									state_q  <= ST_PK_RD;
								end else begin
									state_q <= ST_REG_RD;
								end
							end
							rmts_pkg::ACT_YIELD, rmts_pkg::ACT_DEREGISTER: begin
								state_q <= ST_FND_RD;
							end
							default: begin
								now_q   <= now_q + 1'b1;
								state_q <= ST_TK_RD;
							end
						endcase
					end
				end
				// Admission: sum the shares and find the insertion place.
				ST_REG_RD: begin
					state_q <= (idx_q < count_q) ? ST_REG_DO : ST_REG_CK;
				end
				ST_REG_DO: begin
					total_q <= total_q + TotW'(rd_share);
					if (!pos_found_q && rd_period > period_q) begin
						pos_q       <= idx_q;
						pos_found_q <= 1'b1;
					end
					idx_q   <= idx_p1;
					state_q <= ST_REG_RD;
				end
				ST_REG_CK: begin
					if (div_done) begin
						if (!(total_new < TotW'(limit_q))) begin
							status_q <= rmts_pkg::STS_REFUSED;
							idx_q    <= '0;
							state_q  <= ST_PK_RD;
						end else if (count_q >= CntW'(MAX_TASKS)) begin
							status_q <= rmts_pkg::STS_FULL;
							idx_q    <= '0;
							state_q  <= ST_PK_RD;
						end else begin
							idx_q <= count_q;
							if (!pos_found_q) begin
								pos_q <= count_q;
							end
							state_q <= ST_SHU_RD;
						end
					end
				end
				// Open a slot by moving later entries up by one.
				ST_SHU_RD: begin
					state_q <= (idx_q > pos_q) ? ST_SHU_DO : ST_INS;
				end
				ST_SHU_DO: begin
					idx_q   <= idx_m1;
					state_q <= ST_SHU_RD;
				end
				ST_INS: begin
					count_q <= count_q + 1'b1;
					if (cur_valid_q && pos_q <= CntW'(cur_slot_q)) begin
						cur_slot_q <= cur_slot_q + 1'b1;
					end
					idx_q   <= '0;
					state_q <= ST_PK_RD;
				end
				// First entry with the requested identifier.
				ST_FND_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_FND_DO;
					end else begin
						status_q <= rmts_pkg::STS_UNKNOWN;
						idx_q    <= '0;
						state_q  <= ST_PK_RD;
					end
				end
				ST_FND_DO: begin
					if (rd_id == id_q) begin
						rec_q <= mem_rdata;
						pos_q <= idx_q;
						state_q <= (act_q == rmts_pkg::ACT_YIELD) ? ST_YLD_WR : ST_DSH_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_FND_RD;
					end
				end
				ST_YLD_WR: begin
					if (cur_valid_q && CntW'(cur_slot_q) == idx_q) begin
						cur_valid_q <= 1'b0;
						cur_slot_q  <= '0;
					end
					idx_q   <= '0;
					state_q <= ST_PK_RD;
				end
				// Close the gap by moving later entries down by one.
				ST_DSH_RD: begin
					if (idx_p1 < count_q) begin
						state_q <= ST_DSH_DO;
					end else begin
						count_q <= count_q - 1'b1;
						if (cur_valid_q) begin
							if (CntW'(cur_slot_q) == pos_q) begin
								cur_valid_q <= 1'b0;
								cur_slot_q  <= '0;
							end else if (CntW'(cur_slot_q) > pos_q) begin
								cur_slot_q <= cur_slot_q - 1'b1;
							end
						end
						idx_q   <= '0;
						state_q <= ST_PK_RD;
					end
				end
				ST_DSH_DO: begin
					idx_q   <= idx_p1;
					state_q <= ST_DSH_RD;
				end
				// Millisecond tick over every entry.
				ST_TK_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_TK_DO;
					end else begin
						idx_q   <= '0;
						state_q <= ST_PK_RD;
					end
				end
				ST_TK_DO: begin
					idx_q   <= idx_p1;
					state_q <= ST_TK_RD;
				end
				// Pick the first ready or running entry.
				ST_PK_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_PK_DO;
					end else begin
						cur_valid_q <= 1'b0;
						cur_slot_q  <= '0;
						state_q     <= ST_FIN;
					end
				end
				ST_PK_DO: begin
					if (rd_mode == rmts_pkg::MODE_READY || rd_mode == rmts_pkg::MODE_RUN) begin
						rec_q <= mem_rdata;
						if (cur_valid_q && CntW'(cur_slot_q) == idx_q) begin
							state_q <= ST_FIN;
						end else if (cur_valid_q && CntW'(cur_slot_q) < count_q) begin
							state_q <= ST_PK_ORD;
						end else begin
							state_q <= ST_PK_NEW;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_PK_RD;
					end
				end
				ST_PK_ORD: begin
					state_q <= ST_PK_OWR;
				end
				ST_PK_OWR: begin
					state_q <= ST_PK_NEW;
				end
				ST_PK_NEW: begin
					cur_valid_q <= 1'b1;
					cur_slot_q  <= idx_q[SlotW-1:0];
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= s_tuser;
			id_q        <= s_tdata[IdW-1:0];
			period_q    <= s_tdata[41:22];
			old_valid_q <= cur_valid_q;
			old_id_q    <= cur_valid_q ? cur_id_q : '0;
		end
		if (state_q == ST_PK_NEW) begin
			cur_id_q <= rq_id;
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= {6'd0, switched, rmts_pkg::TASK_ID_W'(new_id), cur_valid_q, status_q};
		end
	end

	rmts_share_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.compute (s_tdata[61:42]),
		.period  (s_tdata[41:22]),
		.done    (div_done),
		.share   (div_share)
	);

	rmts_task_mem #(
		.WIDTH (RecW),
		.DEPTH (MAX_TASKS),
		.AW    (SlotW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The running slot always lies inside the packed table between commands.
	a_slot_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cur_valid_q) |-> (CntW'(cur_slot_q) < count_q))
		else $error("running slot outside the table");

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_TASKS))
		else $error("entry count beyond table depth");

	// An accepted transaction always starts the sequencer.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted transaction left the sequencer idle");

	// Table full is reported for register commands only.
	a_full_on_register: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && status_q == rmts_pkg::STS_FULL)
			|-> (act_q == rmts_pkg::ACT_REGISTER))
		else $error("table full status on a non-register command");

endmodule

`default_nettype wire
